>>> rtl/pic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  // field widths
  localparam int PROB_W   = 32;
  localparam int QUANT_W  = 7;
  localparam int LAMBDA_W = 22;
  localparam int PROB48_W = 49;  // Q0.48 with one integer bit

  // default search bound
  localparam int MAX_K_DEF = 100;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // register select, taken from paddr[3] (8-byte spacing)
  localparam logic REG_RATE_LAMBDA  = 1'b0;
  localparam logic REG_EXP_NEG_RATE = 1'b1;

  localparam logic [PROB48_W-1:0] EXP_NEG_RATE_RST = {1'b1, {(PROB48_W-1){1'b0}}};
  localparam logic [PROB48_W-1:0] PROB48_MAX       = {PROB48_W{1'b1}};

  // term update: 56-bit dividend divided 8 bits per cycle
  localparam int DIVIDEND_W = 56;
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYC    = DIVIDEND_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  // multiplier operands
  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + LAMBDA_W;

endpackage

`default_nettype wire

>>> rtl/poisson_inverse_cdf.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                                   Handshake
// request    start, busy, in_prob[31:0]              taken when start && !busy
// result     out_valid, out_quantile[6:0]            one-cycle strobe, no backpressure
// config     psel, penable, pwrite, paddr[3:0],      APB, pready tied high;
//            pwdata[63:0], prdata[63:0], pready      0x0 rate_lambda, 0x8 exp_neg_rate
//
// One request at a time; busy is high from acceptance until the scan ends.
// Each scan step that misses runs S_ACC (accumulate/compare), then S_MUL_LO
// and S_MUL_HI on the shared 32x22 multiplier (low and high halves of the
// term), then S_DIV, the radix-256 divide by k+1, and returns to S_ACC.
// Reset (rst_n low, synchronous) idles the sequencer and restores the
// registers. The receiver cannot stall: out_valid is high for one cycle.

module poisson_inverse_cdf #(
  parameter int MAX_K = pic_pkg::MAX_K_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [pic_pkg::PROB_W-1:0]      in_prob,
  output logic                                 out_valid,
  output logic [pic_pkg::QUANT_W-1:0]          out_quantile,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pic_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [pic_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pic_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int KW = $clog2(MAX_K + 1);
  localparam int PW = pic_pkg::PROB48_W;
  localparam int DW = pic_pkg::DIVIDEND_W;
  // high partial product: 17-bit upper term times 22-bit lambda
  localparam int HI_PROD_W = PW - pic_pkg::MUL_A_W + pic_pkg::LAMBDA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_MUL_LO = 3'd2;
  localparam logic [2:0] S_MUL_HI = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;

  localparam logic [KW-1:0] K_LAST = KW'(MAX_K - 1);
  localparam logic [KW-1:0] K_MAX  = KW'(MAX_K);
  localparam logic [pic_pkg::DIV_CNT_W-1:0] DIV_LAST =
    pic_pkg::DIV_CNT_W'(pic_pkg::DIV_CYC - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [pic_pkg::LAMBDA_W-1:0]      lambda_r;
  logic [PW-1:0]                     exp_r;
  logic [PW-1:0]                     target_r, target_nxt;
  logic [PW-1:0]                     term_r, term_nxt;
  logic [PW-1:0]                     cum_r, cum_nxt;
  logic [KW-1:0]                     k_r, k_nxt;
  logic [DW-1:0]                     q_r, q_nxt;
  logic [KW-1:0]                     rem_r, rem_nxt;
  logic [pic_pkg::DIV_CNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [pic_pkg::QUANT_W-1:0]       out_q_r, out_q_nxt;

  logic                              cfg_wr;
  logic [PW:0]                       cum_sum;
  logic [PW-1:0]                     cum_sat;
  logic [pic_pkg::MUL_A_W-1:0]       mul_a;
  logic [pic_pkg::PROD_W-1:0]        prod;
  logic [KW-1:0]                     divisor;
  logic [DW-1:0]                     dq;
  logic [KW-1:0]                     dr;
  logic [KW:0]                       dr2;

  assign pready = 1'b1;
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[3] == pic_pkg::REG_EXP_NEG_RATE) begin
      prdata = pic_pkg::CFG_DATA_W'(exp_r);
    end else begin
      prdata = pic_pkg::CFG_DATA_W'(lambda_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= '0;
      exp_r    <= pic_pkg::EXP_NEG_RATE_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == pic_pkg::REG_EXP_NEG_RATE) begin
        exp_r <= pwdata[PW-1:0];
      end else begin
        lambda_r <= pwdata[pic_pkg::LAMBDA_W-1:0];
      end
    end
  end

  // saturating running sum
  assign cum_sum = {1'b0, cum_r} + {1'b0, term_r};
  assign cum_sat = cum_sum[PW] ? pic_pkg::PROB48_MAX : cum_sum[PW-1:0];

  // shared multiplier: low 32 bits of term, then high 17 bits
  assign mul_a = (state_r == S_MUL_LO) ? term_r[pic_pkg::MUL_A_W-1:0]
               : pic_pkg::MUL_A_W'(term_r[PW-1:pic_pkg::MUL_A_W]);
  assign prod  = pic_pkg::PROD_W'(mul_a) * pic_pkg::PROD_W'(lambda_r);

  assign divisor = k_r + KW'(1);

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    dq  = q_r;
    dr  = rem_r;
    dr2 = '0;
    for (int j = 0; j < pic_pkg::DIV_BITS; j++) begin
      dr2 = {dr, dq[DW-1]};
      dq  = {dq[DW-2:0], 1'b0};
      if (dr2 >= {1'b0, divisor}) begin
        dr2   = dr2 - {1'b0, divisor};
        dq[0] = 1'b1;
      end
      dr = dr2[KW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    term_nxt      = term_r;
    cum_nxt       = cum_r;
    k_nxt         = k_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = 1'b0;
    out_q_nxt     = out_q_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          target_nxt = {1'b0, in_prob, 16'b0};
          term_nxt   = exp_r;
          cum_nxt    = '0;
          k_nxt      = '0;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        cum_nxt = cum_sat;
        if (cum_sat >= target_r) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = pic_pkg::QUANT_W'(k_r);
          state_nxt     = S_IDLE;
        end else if (k_r == K_LAST) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = pic_pkg::QUANT_W'(K_MAX);
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        q_nxt     = DW'(prod >> 16);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        // high partial product is exact, so the shift loses nothing
        q_nxt     = q_r + DW'({prod[HI_PROD_W-1:0], 16'b0});
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        q_nxt    = dq;
        rem_nxt  = dr;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_LAST) begin
          term_nxt  = (dq > DW'(pic_pkg::PROB48_MAX)) ? pic_pkg::PROB48_MAX : dq[PW-1:0];
          k_nxt     = k_r + KW'(1);
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      term_r      <= '0;
      cum_r       <= '0;
      k_r         <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      term_r      <= term_nxt;
      cum_r       <= cum_nxt;
      k_r         <= k_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    out_q_r  <= out_q_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_quantile = out_q_r;

endmodule

`default_nettype wire

>>> dv/poisson_quantile_checker.sv
`timescale 1ns / 1ps

module poisson_quantile_checker #(
  parameter int MAX_K = pic_pkg::MAX_K_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [pic_pkg::PROB_W-1:0]      in_prob,
  input  logic                            out_valid,
  input  logic [pic_pkg::QUANT_W-1:0]     out_quantile,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pic_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pic_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic [pic_pkg::CFG_DATA_W-1:0]  prdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending
);
  import pic_pkg::*;

  logic [LAMBDA_W-1:0] lambda_q;
  logic [PROB48_W-1:0] exp_neg_q;
  logic [QUANT_W-1:0]  quantile_due[$];
  int                  mism;

  assign errors = mism;

  initial begin
    mism = 0;
    pending = 0;
    lambda_q = '0;
    exp_neg_q = EXP_NEG_RATE_RST;
  end

  // linear CDF scan in Q0.48, truncating multiply/shift/divide per step
  function automatic logic [QUANT_W-1:0] poisson_quantile(input logic [PROB_W-1:0] p);
    logic [PROB48_W-1:0] goal;
    logic [PROB48_W-1:0] term;
    logic [PROB48_W-1:0] cum;
    logic [PROB48_W:0]   sum;
    logic [70:0]         prod;
    logic [54:0]         scaled;
    logic [54:0]         quot;
    logic                found;
    logic [QUANT_W-1:0]  q;
    int unsigned         k;
    goal = {1'b0, p, 16'h0000};
    term = exp_neg_q;
    cum = '0;
    found = 1'b0;
    q = QUANT_W'(MAX_K);
    for (k = 0; k < MAX_K && !found; k++) begin
      sum = {1'b0, cum} + {1'b0, term};
      cum = sum[PROB48_W] ? PROB48_MAX : sum[PROB48_W-1:0];
      if (cum >= goal) begin
        found = 1'b1;
        q = QUANT_W'(k);
      end else begin
        prod = 71'(term) * 71'(lambda_q);
        scaled = prod[70:16];
        quot = scaled / 55'(k + 1);
        term = (quot > 55'(PROB48_MAX)) ? PROB48_MAX : quot[PROB48_W-1:0];
      end
    end
    return q;
  endfunction

  task automatic report(input string msg);
    if (mism < 10) $display("mismatch @%0t: %s", $realtime, msg);
    mism++;
  endtask

  always @(posedge clk) begin
    logic [QUANT_W-1:0]    want;
    logic [CFG_DATA_W-1:0] reg_val;
    if (!rst_n) begin
      quantile_due.delete();
      lambda_q = '0;
      exp_neg_q = EXP_NEG_RATE_RST;
    end else begin
      if (out_valid) begin
        if (quantile_due.size() == 0) begin
          report($sformatf("unexpected result quantile=%0d", out_quantile));
        end else begin
          want = quantile_due.pop_front();
          if (out_quantile !== want)
            report($sformatf("quantile expected %0d actual %0d", want, out_quantile));
        end
      end
      if (start && !busy) quantile_due.push_back(poisson_quantile(in_prob));
      if (psel && penable && pready && !pwrite) begin
        reg_val = (paddr[3] == REG_RATE_LAMBDA) ? CFG_DATA_W'(lambda_q)
                                               : CFG_DATA_W'(exp_neg_q);
        if (prdata !== reg_val)
          report($sformatf("readback 0x%0h expected 0x%0h actual 0x%0h",
                           paddr, reg_val, prdata));
      end
      if (psel && penable && pready && pwrite) begin
        if (paddr[3] == REG_RATE_LAMBDA) lambda_q = pwdata[LAMBDA_W-1:0];
        else exp_neg_q = pwdata[PROB48_W-1:0];
      end
    end
    pending <= quantile_due.size();
  end

endmodule

>>> dv/tb_poisson_inverse_cdf.sv
`timescale 1ns / 1ps

module tb_poisson_inverse_cdf;
  import pic_pkg::*;

  localparam int RAND_ITEMS  = 1850;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int DRAIN_WAIT  = 10 * MAX_K_DEF + 100;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [PROB_W-1:0]     in_prob;
  logic                  out_valid;
  logic [QUANT_W-1:0]    out_quantile;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  int                    cycles;
  int                    sent;

  poisson_inverse_cdf u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_prob      (in_prob),
    .out_valid    (out_valid),
    .out_quantile (out_quantile),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  poisson_quantile_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_prob      (in_prob),
    .out_valid    (out_valid),
    .out_quantile (out_quantile),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL poisson_inverse_cdf");
      $finish;
    end
  end

  // exp(-lambda) in Q0.48 for lambda in Q6.16, split to stay within 32-bit $rtoi
  function automatic logic [PROB48_W-1:0] exp_q48(input logic [LAMBDA_W-1:0] lam);
    real r;
    int  hi;
    int  lo;
    r = $exp(-(lam / 65536.0)) * 281474976710656.0;
    hi = $rtoi(r / 16777216.0);
    lo = $rtoi(r - hi * 16777216.0);
    return (PROB48_W'(hi) << 24) + PROB48_W'(lo);
  endfunction

  function automatic logic [PROB_W-1:0] pick_prob();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom;
    if (sel < 70) return 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
    if (sel < 82) return $urandom_range(0, 4096);
    if (sel < 86) return '0;
    if (sel < 90) return '1;
    return {16'hFFFF, 16'($urandom)};
  endfunction

  // idle cycles before a request; none while sent is in [700, 1000)
  function automatic int idle_gap();
    if (sent >= 700 && sent < 1000) return 0;
    if ($urandom_range(0, 99) < 15) return $urandom_range(1, 24);
    return 0;
  endfunction

  task automatic send_request(input logic [PROB_W-1:0] p);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_prob <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic sel_reg,
                          input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel_reg, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // upper bits of pwdata carry noise; the block keeps only the register width
  task automatic set_rate(input logic [LAMBDA_W-1:0] lam, input logic [PROB48_W-1:0] expv);
    logic [CFG_DATA_W-1:0] w;
    wait_drained();
    w = {$urandom, $urandom};
    w[LAMBDA_W-1:0] = lam;
    apb_xfer(1'b1, REG_RATE_LAMBDA, w);
    w = {$urandom, $urandom};
    w[PROB48_W-1:0] = expv;
    apb_xfer(1'b1, REG_EXP_NEG_RATE, w);
    apb_xfer(1'b0, REG_RATE_LAMBDA, '0);
    apb_xfer(1'b0, REG_EXP_NEG_RATE, '0);
  endtask

  initial begin
    logic [LAMBDA_W-1:0] lam;
    logic [PROB48_W-1:0] expv;
    int                  kind;
    int                  batch;
    int                  j;

    rst_n = 1'b0;
    start = 1'b0;
    in_prob = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at their reset values: lambda 0, exp(-lambda) = 1.0
    send_request('0);
    send_request('1);
    send_request(32'h0000_0001);

    // largest legal mean
    set_rate(22'd2097152, exp_q48(22'd2097152));
    send_request('0);
    send_request(32'h0000_0001);
    send_request(32'h8000_0000);
    send_request(32'h5555_5555);
    send_request(32'hAAAA_AAAA);
    send_request('1);

    // zero mean
    set_rate('0, EXP_NEG_RATE_RST);
    send_request('1);
    send_request('0);

    // oversized term and sum: both saturate
    set_rate('1, 49'd1);
    send_request('1);
    send_request(32'h7FFF_FFFF);
    set_rate('1, PROB48_MAX);
    send_request('1);
    send_request('0);

    // exp(-lambda) = 0: CDF never moves, only prob 0 is found
    set_rate(22'd65536, '0);
    send_request('0);
    send_request(32'h0000_0001);
    send_request('1);

    // smallest nonzero mean
    set_rate(22'd1, exp_q48(22'd1));
    send_request('1);
    send_request(32'h1234_5678);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // arbitrary register contents, mostly unreachable targets; keep short
        lam = LAMBDA_W'($urandom);
        expv = PROB48_W'({$urandom, $urandom}) >> $urandom_range(0, 48);
        batch = 25;
      end else begin
        if (kind == 1) lam = $urandom_range(0, 262144);
        else lam = $urandom_range(0, 2097152);
        expv = exp_q48(lam) ^ PROB48_W'($urandom_range(0, 3));
        batch = $urandom_range(80, 200);
      end
      set_rate(lam, expv);
      for (j = 0; j < batch && sent < RAND_ITEMS; j++) begin
        send_request(pick_prob());
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("PASS poisson_inverse_cdf");
    end else begin
      $display("FAIL poisson_inverse_cdf");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pic_pkg.sv
rtl/poisson_inverse_cdf.sv
dv/poisson_quantile_checker.sv
dv/tb_poisson_inverse_cdf.sv
